// ===== rtl/chained_hash_table_engine_defines.svh =====
// Assertion macros shared by the chained hash table engine RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef CHAINED_HASH_TABLE_ENGINE_DEFINES_SVH
`define CHAINED_HASH_TABLE_ENGINE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CHT_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CHT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/cht_pkg.sv =====
// Shared types, codes and constants of the chained hash table engine.
// No dependencies.
package cht_pkg;

	localparam int BUCKET_BITS_DEF  = 10;
	localparam int POOL_ENTRIES_DEF = 1024;
	localparam int SLOT_W           = 10;
	localparam int KEY_W            = 64;
	localparam int MIX_SHIFT        = 33;

	localparam logic [63:0] MIX_C1 = 64'hff51afd7ed558ccd;
	localparam logic [63:0] MIX_C2 = 64'hc4ceb9fe1a85ec53;

	localparam logic [2:0] STAT_FOUND    = 3'd0;
	localparam logic [2:0] STAT_INSERTED = 3'd1;
	localparam logic [2:0] STAT_FULL     = 3'd2;
	localparam logic [2:0] STAT_REMOVED  = 3'd3;
	localparam logic [2:0] STAT_MISSED   = 3'd4;

	localparam logic FUNC_FIND_INSERT = 1'b0;
	localparam logic FUNC_REMOVE      = 1'b1;

	typedef struct packed {
		logic             func;
		logic [KEY_W-1:0] key;
	} req_t;

	typedef struct packed {
		logic [2:0]        status;
		logic [SLOT_W-1:0] slot;
	} res_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_MUL,
		S_XS,
		S_HEAD,
		S_HEAD_WT,
		S_NODE_RD,
		S_NODE_CMP,
		S_COMMIT
	} state_t;

	typedef struct packed {
		logic       load;
		logic       mul_en;
		logic [1:0] mul_step;
		logic       mul_phase;
		logic       xs;
		logic       clr_en;
		logic       head_rd;
		logic       head_take;
		logic       node_rd;
		logic       node_adv;
		logic       commit;
		logic       commit_hit;
	} dp_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic head_valid;
		logic key_hit;
		logic link_valid;
		logic steps_last;
	} dp_sts_t;

endpackage

// ===== rtl/cht_datapath.sv =====
// Datapath: key mixing, bucket head, node and free stack memories, result register.
// Depends on cht_pkg and chained_hash_table_engine_defines.svh.
`include "chained_hash_table_engine_defines.svh"

module cht_datapath import cht_pkg::*; #(
	parameter int BUCKET_BITS  = BUCKET_BITS_DEF,
	parameter int POOL_ENTRIES = POOL_ENTRIES_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  req_t    req,
	input  dp_cmd_t cmd,
	output dp_sts_t sts,
	output logic    done,
	output res_t    result
);

	localparam int SW  = $clog2(POOL_ENTRIES);
	localparam int CW  = $clog2(POOL_ENTRIES + 1);
	localparam int NB  = 1 << BUCKET_BITS;
	localparam int SXW = (SW > SLOT_W) ? SW : SLOT_W;

	logic             func_q;
	logic [KEY_W-1:0] key_q;
	logic [63:0]      k_q;
	logic [63:0]      acc_q;
	logic [31:0]      a_op;
	logic [31:0]      b_op;
	logic [63:0]      cst;
	logic [63:0]      prod;

	logic [BUCKET_BITS-1:0] clr_q;
	logic [BUCKET_BITS-1:0] bucket;
	logic [SW:0]            head_mem [NB];
	logic [SW:0]            hd_q;
	logic                   head_we;
	logic [SW:0]            head_wd;

	logic [KEY_W-1:0] key_mem [POOL_ENTRIES];
	logic [SW:0]      link_mem [POOL_ENTRIES];
	logic [KEY_W-1:0] nkey_q;
	logic [SW:0]      nlink_q;
	logic             link_we;
	logic [SW-1:0]    link_wa;
	logic [SW:0]      link_wd;

	logic [SW-1:0] fs_mem [POOL_ENTRIES];
	logic [SW-1:0] fs_q;
	logic [CW-1:0] fc_q;
	logic [CW-1:0] mark_q;

	logic [SW-1:0] cur_q;
	logic [SW-1:0] prev_q;
	logic          have_prev_q;
	logic [CW-1:0] steps_q;

	logic          do_insert;
	logic          do_remove;
	logic          do_push;
	logic [SW-1:0] alloc;
	logic [SW-1:0] slot_sel;
	logic [2:0]    stat_sel;
	logic [SXW-1:0] slot_x;

	logic done_q;
	res_t res_q;

	assign bucket = k_q[63 -: BUCKET_BITS];
	assign cst    = cmd.mul_phase ? MIX_C2 : MIX_C1;
	assign a_op   = (cmd.mul_step == 2'd2) ? k_q[63:32] : k_q[31:0];
	assign b_op   = (cmd.mul_step == 2'd1) ? cst[63:32] : cst[31:0];
	assign prod   = 64'(a_op) * 64'(b_op);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q <= req.func;
			key_q  <= req.key;
			k_q    <= req.key ^ (req.key >> MIX_SHIFT);
		end else if (cmd.xs) begin
			k_q <= acc_q ^ (acc_q >> MIX_SHIFT);
		end
		if (cmd.mul_en) begin
			if (cmd.mul_step == 2'd0) begin
				acc_q <= prod;
			end else begin
				acc_q <= acc_q + {prod[31:0], 32'h0};
			end
		end
	end

	assign do_insert = cmd.commit && (func_q == FUNC_FIND_INSERT) && !cmd.commit_hit
		&& (fc_q != '0);
	assign do_remove = cmd.commit && (func_q == FUNC_REMOVE) && cmd.commit_hit;
	assign do_push   = do_remove && (fc_q < CW'(POOL_ENTRIES));
	assign alloc     = (fc_q > mark_q) ? fs_q : SW'(CW'(POOL_ENTRIES) - fc_q);

	always_comb begin
		head_we = 1'b0;
		head_wd = nlink_q;
		link_we = 1'b0;
		link_wa = prev_q;
		link_wd = nlink_q;
		if (do_insert) begin
			head_we = 1'b1;
			head_wd = {1'b1, alloc};
			link_we = 1'b1;
			link_wa = alloc;
			link_wd = hd_q;
		end else if (do_remove) begin
			head_we = !have_prev_q;
			link_we = have_prev_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.clr_en) begin
			head_mem[clr_q] <= '0;
		end else if (head_we) begin
			head_mem[bucket] <= head_wd;
		end
		if (cmd.head_rd) begin
			hd_q <= head_mem[bucket];
			fs_q <= fs_mem[SW'(fc_q - 1'b1)];
		end
	end

	always_ff @(posedge clk) begin
		if (do_insert) begin
			key_mem[alloc] <= key_q;
		end
		if (link_we) begin
			link_mem[link_wa] <= link_wd;
		end
		if (cmd.node_rd) begin
			nkey_q  <= key_mem[cur_q];
			nlink_q <= link_mem[cur_q];
		end
		if (do_push) begin
			fs_mem[SW'(fc_q)] <= cur_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.head_take) begin
			cur_q       <= hd_q[SW-1:0];
			have_prev_q <= 1'b0;
			steps_q     <= '0;
		end else if (cmd.node_adv) begin
			prev_q      <= cur_q;
			cur_q       <= nlink_q[SW-1:0];
			have_prev_q <= 1'b1;
			steps_q     <= steps_q + 1'b1;
		end
	end

	always_comb begin
		slot_sel = '0;
		if (func_q == FUNC_FIND_INSERT) begin
			if (cmd.commit_hit) begin
				stat_sel = STAT_FOUND;
				slot_sel = cur_q;
			end else if (fc_q == '0) begin
				stat_sel = STAT_FULL;
			end else begin
				stat_sel = STAT_INSERTED;
				slot_sel = alloc;
			end
		end else begin
			if (cmd.commit_hit) begin
				stat_sel = STAT_REMOVED;
				slot_sel = cur_q;
			end else begin
				stat_sel = STAT_MISSED;
			end
		end
		slot_x = SXW'(slot_sel);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q  <= '0;
			fc_q   <= CW'(POOL_ENTRIES);
			mark_q <= CW'(POOL_ENTRIES);
			done_q <= 1'b0;
		end else begin
			if (cmd.clr_en) begin
				clr_q <= clr_q + 1'b1;
			end
			if (do_insert) begin
				fc_q <= fc_q - 1'b1;
			end else if (do_push) begin
				fc_q <= fc_q + 1'b1;
				if (fc_q < mark_q) begin
					mark_q <= fc_q;
				end
			end
			done_q <= cmd.commit;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			res_q.status <= stat_sel;
			res_q.slot   <= slot_x[SLOT_W-1:0];
		end
	end

	assign sts.clr_last   = &clr_q;
	assign sts.head_valid = hd_q[SW];
	assign sts.key_hit    = (nkey_q == key_q);
	assign sts.link_valid = nlink_q[SW];
	assign sts.steps_last = (steps_q == CW'(POOL_ENTRIES - 1));

	assign done   = done_q;
	assign result = res_q;

	`CHT_ASSERT_NEXT(a_commit_done, clk, arst_n, cmd.commit, done, "commit gave no result beat")
	`CHT_ASSERT_SAME(a_fc_bound, clk, arst_n, 1'b1, (fc_q <= CW'(POOL_ENTRIES)) && (mark_q <= CW'(POOL_ENTRIES)), "free count out of range")
	`CHT_ASSERT_SAME(a_insert_pop, clk, arst_n, done && (result.status == STAT_INSERTED), fc_q == CW'($past(fc_q) - 1'b1), "insert did not pop the free stack")

endmodule

// ===== rtl/cht_ctrl.sv =====
// Controller state machine sequencing the hash, the chain walk and the commit.
// Depends on cht_pkg and chained_hash_table_engine_defines.svh.
`include "chained_hash_table_engine_defines.svh"

module cht_ctrl import cht_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  dp_sts_t sts,
	output logic    busy,
	output dp_cmd_t cmd
);

	state_t     state_q;
	state_t     state_d;
	logic [1:0] step_q;
	logic       phase_q;
	logic       hit_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR:    if (sts.clr_last) state_d = S_IDLE;
			S_IDLE:     if (start) state_d = S_MUL;
			S_MUL:      if (step_q == 2'd2) state_d = S_XS;
			S_XS:       state_d = phase_q ? S_HEAD : S_MUL;
			S_HEAD:     state_d = S_HEAD_WT;
			S_HEAD_WT:  state_d = sts.head_valid ? S_NODE_RD : S_COMMIT;
			S_NODE_RD:  state_d = S_NODE_CMP;
			S_NODE_CMP: begin
				if (sts.key_hit || !sts.link_valid || sts.steps_last) begin
					state_d = S_COMMIT;
				end else begin
					state_d = S_NODE_RD;
				end
			end
			S_COMMIT:   state_d = S_IDLE;
			default:    state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd           = '0;
		cmd.mul_step  = step_q;
		cmd.mul_phase = phase_q;
		cmd.commit_hit = hit_q;
		case (state_q)
			S_CLEAR:    cmd.clr_en = 1'b1;
			S_IDLE:     cmd.load = start;
			S_MUL:      cmd.mul_en = 1'b1;
			S_XS:       cmd.xs = 1'b1;
			S_HEAD:     cmd.head_rd = 1'b1;
			S_HEAD_WT:  cmd.head_take = 1'b1;
			S_NODE_RD:  cmd.node_rd = 1'b1;
			S_NODE_CMP: cmd.node_adv = !sts.key_hit;
			S_COMMIT:   cmd.commit = 1'b1;
			default:    cmd.commit = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			step_q  <= '0;
			phase_q <= 1'b0;
			hit_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_IDLE) begin
				step_q  <= '0;
				phase_q <= 1'b0;
			end else if (state_q == S_MUL) begin
				step_q <= (step_q == 2'd2) ? 2'd0 : step_q + 2'd1;
			end else if (state_q == S_XS) begin
				phase_q <= 1'b1;
			end
			if (state_q == S_HEAD_WT) begin
				hit_q <= 1'b0;
			end else if (state_q == S_NODE_CMP) begin
				hit_q <= sts.key_hit;
			end
		end
	end

	assign busy = (state_q != S_IDLE);

	`CHT_ASSERT_NEXT(a_start_busy, clk, arst_n, start && !busy, busy, "accepted beat did not raise busy")
	`CHT_ASSERT_SAME(a_one_cmd, clk, arst_n, 1'b1, $onehot0({cmd.load, cmd.mul_en, cmd.xs, cmd.clr_en, cmd.head_rd, cmd.head_take, cmd.node_rd, cmd.commit}), "conflicting datapath commands")
	`CHT_ASSERT_NEXT(a_commit_idle, clk, arst_n, cmd.commit, state_q == S_IDLE, "commit did not return to idle")

endmodule

// ===== rtl/chained_hash_table_engine.sv =====
// Top level of the chained hash table engine: controller plus datapath.
// Depends on cht_pkg, cht_ctrl and cht_datapath.
//
// channel   signals              direction  accepted when
// request   start, busy, req     in         start high and busy low at clk rise
// result    done, result         out        every cycle done is high
//
// A request ends in a one-cycle done beat: two 64-bit multiplies are each three
// passes of one 32x32 multiplier, and every chain node visited costs a registered
// read of the node memories. After reset busy stays high while all bucket heads
// are cleared, one per cycle. Results cannot be stalled.
module chained_hash_table_engine import cht_pkg::*; #(
	parameter int BUCKET_BITS  = BUCKET_BITS_DEF,
	parameter int POOL_ENTRIES = POOL_ENTRIES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  req_t req,
	output logic done,
	output res_t result
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	cht_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.busy   (busy),
		.cmd    (cmd)
	);

	cht_datapath #(
		.BUCKET_BITS  (BUCKET_BITS),
		.POOL_ENTRIES (POOL_ENTRIES)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.sts    (sts),
		.done   (done),
		.result (result)
	);

endmodule
